// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with a reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/plq_pkg.sv
// ----------------------------------------------------------------------------
// plq_pkg
// Word types, codes and control structs of the priority transmit queue.
// ----------------------------------------------------------------------------
`default_nettype none

package plq_pkg;

   localparam int PRIO_W  = 8;
   localparam int FIELD_W = 32;
   localparam int OCC_W   = 7;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef struct packed {
      logic               op;
      logic [PRIO_W-1:0]  priority_req;
      logic [FIELD_W-1:0] payload;
   } req_type;

   typedef struct packed {
      logic               done_res;
      logic [FIELD_W-1:0] removed_payload;
      logic               head_valid;
      logic [FIELD_W-1:0] head_payload;
      logic [PRIO_W-1:0]  head_priority;
      logic [OCC_W-1:0]   occupancy;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_LINK_NEW,
      S_LINK_PRED,
      S_POP_NEXT,
      S_POP_HEAD,
      S_RESP
   } state_type;

   typedef struct packed {
      logic link_we;
      logic data_we;
   } store_wr_type;

   typedef struct packed {
      logic start;
      logic set_en;
      logic clear_en;
   } scan_ctrl_type;

   typedef struct packed {
      logic busy;
      logic found;
   } scan_status_type;

endpackage

`default_nettype wire

// File: design/plq_store.sv
// ----------------------------------------------------------------------------
// plq_store
// Slot memory: next link, priority and payload, one write and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module plq_store #(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6,
   parameter int PAY_W = 32
) (
   input  wire                          clock,
   input  plq_pkg::store_wr_type        wr_ctrl,
   input  wire [IDX_W-1:0]              wr_addr,
   input  wire [IDX_W-1:0]              wr_next,
   input  wire [plq_pkg::PRIO_W-1:0]    wr_prio,
   input  wire [PAY_W-1:0]              wr_pay,
   input  wire [IDX_W-1:0]              rd_addr,
   output logic [IDX_W-1:0]             rd_next,
   output logic [plq_pkg::PRIO_W-1:0]   rd_prio,
   output logic [PAY_W-1:0]             rd_pay
);

   logic [IDX_W-1:0]           next_mem [DEPTH];
   logic [plq_pkg::PRIO_W-1:0] prio_mem [DEPTH];
   logic [PAY_W-1:0]           pay_mem  [DEPTH];

   logic [IDX_W-1:0]           rd_next_ff;
   logic [plq_pkg::PRIO_W-1:0] rd_prio_ff;
   logic [PAY_W-1:0]           rd_pay_ff;

   always_ff @(posedge clock) begin
      if (wr_ctrl.link_we) begin
         next_mem[wr_addr] <= wr_next;
      end
      if (wr_ctrl.data_we) begin
         prio_mem[wr_addr] <= wr_prio;
         pay_mem[wr_addr]  <= wr_pay;
      end
      rd_next_ff <= next_mem[rd_addr];
      rd_prio_ff <= prio_mem[rd_addr];
      rd_pay_ff  <= pay_mem[rd_addr];
   end

   assign rd_next = rd_next_ff;
   assign rd_prio = rd_prio_ff;
   assign rd_pay  = rd_pay_ff;

endmodule

`default_nettype wire

// File: design/plq_slot_scan.sv
// ----------------------------------------------------------------------------
// plq_slot_scan
// Slot occupancy bits and a one-bit-per-cycle search for the lowest free slot.
// ----------------------------------------------------------------------------
`default_nettype none

module plq_slot_scan #(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6
) (
   input  wire                       clock,
   input  wire                       reset,
   input  plq_pkg::scan_ctrl_type    ctrl,
   input  wire [IDX_W-1:0]           set_idx,
   input  wire [IDX_W-1:0]           clear_idx,
   output plq_pkg::scan_status_type  status,
   output logic [IDX_W-1:0]          free_slot
);

   logic [DEPTH-1:0] used_ff, used_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             found_ff, found_in;

   always_comb begin
      used_in  = used_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      found_in = found_ff;
      if (ctrl.set_en) begin
         used_in[set_idx] = 1'b1;
      end
      if (ctrl.clear_en) begin
         used_in[clear_idx] = 1'b0;
      end
      if (ctrl.start) begin
         cnt_in   = '0;
         busy_in  = 1'b1;
         found_in = 1'b0;
      end else if (busy_ff) begin
         // stop on the first free bit, cnt then holds the slot
         if (!used_ff[cnt_ff]) begin
            busy_in  = 1'b0;
            found_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         cnt_ff   <= '0;
         busy_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         used_ff  <= used_in;
         cnt_ff   <= cnt_in;
         busy_ff  <= busy_in;
         found_ff <= found_in;
      end
   end

   assign status.busy  = busy_ff;
   assign status.found = found_ff;
   assign free_slot    = cnt_ff;

endmodule

`default_nettype wire

// File: design/priority_linked_tx_queue.sv
// ----------------------------------------------------------------------------
// priority_linked_tx_queue
// Transmit queue kept as a linked list sorted by priority (smaller first).
//
// Request word: op (insert or remove head), priority_req, payload. It is
// taken when req_valid is high and req_stall is low; req_stall stays high
// while a word is being worked on, so one word is in flight at a time.
// Every request gives one response word with the outcome and the head and
// occupancy after the step, held in an output register until taken.
// Insert: walk past the entries of equal or smaller priority, then write the
// new entry into the lowest free slot once the search has found it and link
// the predecessor to it, a step skipped when it lands at the head. The walk
// follows the next links through the single read port of the slot memory,
// one entry per cycle, while the free slot search runs beside it.
// Remove: two memory reads, the old head's link, then the new head's data.
// A full insert or an empty remove goes straight to the response, done_res low.
// Reset empties the queue at once; slot memory is not cleared.
// A stalled response holds its word, and the block waits in the response
// state, with req_stall high, until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_linked_tx_queue #(
   parameter int QUEUE_DEPTH   = 64,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  plq_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output plq_pkg::rsp_type  rsp_data
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   plq_pkg::state_type         state_ff, state_in;
   plq_pkg::req_type           item_ff, item_in;
   logic [IDX_W-1:0]           head_ff, head_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [plq_pkg::PRIO_W-1:0] head_prio_ff, head_prio_in;
   logic [PAYLOAD_WIDTH-1:0]   head_pay_ff, head_pay_in;
   logic [IDX_W-1:0]           cur_ff, cur_in;
   logic [IDX_W-1:0]           pred_ff, pred_in;
   logic [CNT_W-1:0]           step_ff, step_in;
   logic                       done_ff, done_in;
   logic [PAYLOAD_WIDTH-1:0]   removed_ff, removed_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   plq_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   plq_pkg::store_wr_type      wr_ctrl;
   logic [IDX_W-1:0]           wr_addr;
   logic [IDX_W-1:0]           wr_next;
   logic [plq_pkg::PRIO_W-1:0] wr_prio;
   logic [PAYLOAD_WIDTH-1:0]   wr_pay;
   logic [IDX_W-1:0]           rd_addr;
   logic [IDX_W-1:0]           rd_next;
   logic [plq_pkg::PRIO_W-1:0] rd_prio;
   logic [PAYLOAD_WIDTH-1:0]   rd_pay;

   plq_pkg::scan_ctrl_type     scan_ctrl;
   plq_pkg::scan_status_type   scan_status;
   logic [IDX_W-1:0]           scan_slot;

   logic                       queue_full;
   logic                       queue_empty;

   plq_store #(
      .DEPTH (QUEUE_DEPTH),
      .IDX_W (IDX_W),
      .PAY_W (PAYLOAD_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_ctrl (wr_ctrl),
      .wr_addr (wr_addr),
      .wr_next (wr_next),
      .wr_prio (wr_prio),
      .wr_pay  (wr_pay),
      .rd_addr (rd_addr),
      .rd_next (rd_next),
      .rd_prio (rd_prio),
      .rd_pay  (rd_pay)
   );

   plq_slot_scan #(
      .DEPTH (QUEUE_DEPTH),
      .IDX_W (IDX_W)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (scan_ctrl),
      .set_idx   (scan_slot),
      .clear_idx (head_ff),
      .status    (scan_status),
      .free_slot (scan_slot)
   );

   assign queue_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign queue_empty = (count_ff == '0);

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      head_prio_in = head_prio_ff;
      head_pay_in  = head_pay_ff;
      cur_in       = cur_ff;
      pred_in      = pred_ff;
      step_in      = step_ff;
      done_in      = done_ff;
      removed_in   = removed_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      wr_ctrl   = '0;
      wr_addr   = scan_slot;
      wr_next   = cur_ff;
      wr_prio   = item_ff.priority_req;
      wr_pay    = PAYLOAD_WIDTH'(item_ff.payload);
      rd_addr   = head_ff;
      scan_ctrl = '0;

      case (state_ff)
         plq_pkg::S_IDLE: begin
            if (req_valid) begin
               item_in    = req_data;
               done_in    = 1'b0;
               removed_in = '0;
               step_in    = '0;
               cur_in     = head_ff;
               pred_in    = head_ff;
               if (req_data.op == plq_pkg::OP_INSERT) begin
                  if (queue_full) begin
                     state_in = plq_pkg::S_RESP;
                  end else begin
                     scan_ctrl.start = 1'b1;
                     state_in        = plq_pkg::S_WALK;
                  end
               end else begin
                  if (queue_empty) begin
                     state_in = plq_pkg::S_RESP;
                  end else begin
                     state_in = plq_pkg::S_POP_NEXT;
                  end
               end
            end
         end
         plq_pkg::S_WALK: begin
            // read data belongs to cur_ff; stop before the first larger priority
            if (step_ff == count_ff || rd_prio > item_ff.priority_req) begin
               state_in = plq_pkg::S_LINK_NEW;
            end else begin
               pred_in = cur_ff;
               cur_in  = rd_next;
               step_in = step_ff + CNT_W'(1);
               rd_addr = rd_next;
            end
         end
         plq_pkg::S_LINK_NEW: begin
            if (!scan_status.busy && scan_status.found) begin
               wr_ctrl.link_we  = 1'b1;
               wr_ctrl.data_we  = 1'b1;
               wr_addr          = scan_slot;
               wr_next          = (step_ff == '0) ? head_ff : cur_ff;
               scan_ctrl.set_en = 1'b1;
               count_in         = count_ff + CNT_W'(1);
               done_in          = 1'b1;
               if (step_ff == '0) begin
                  head_in      = scan_slot;
                  head_prio_in = item_ff.priority_req;
                  head_pay_in  = PAYLOAD_WIDTH'(item_ff.payload);
                  state_in     = plq_pkg::S_RESP;
               end else begin
                  state_in = plq_pkg::S_LINK_PRED;
               end
            end
         end
         plq_pkg::S_LINK_PRED: begin
            wr_ctrl.link_we = 1'b1;
            wr_addr         = pred_ff;
            wr_next         = scan_slot;
            state_in        = plq_pkg::S_RESP;
         end
         plq_pkg::S_POP_NEXT: begin
            // rd_next holds the old head's successor
            scan_ctrl.clear_en = 1'b1;
            removed_in         = head_pay_ff;
            done_in            = 1'b1;
            count_in           = count_ff - CNT_W'(1);
            head_in            = rd_next;
            rd_addr            = rd_next;
            state_in           = plq_pkg::S_POP_HEAD;
         end
         plq_pkg::S_POP_HEAD: begin
            head_prio_in = rd_prio;
            head_pay_in  = rd_pay;
            state_in     = plq_pkg::S_RESP;
         end
         plq_pkg::S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.done_res        = done_ff;
               rsp_data_in.removed_payload = plq_pkg::FIELD_W'(removed_ff);
               rsp_data_in.head_valid      = !queue_empty;
               rsp_data_in.head_payload    = queue_empty ? '0
                                           : plq_pkg::FIELD_W'(head_pay_ff);
               rsp_data_in.head_priority   = queue_empty ? '0 : head_prio_ff;
               rsp_data_in.occupancy       = plq_pkg::OCC_W'(count_ff);
               state_in                    = plq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = plq_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plq_pkg::S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      head_prio_ff <= head_prio_in;
      head_pay_ff  <= head_pay_in;
      cur_ff       <= cur_in;
      pred_ff      <= pred_in;
      step_ff      <= step_in;
      done_ff      <= done_in;
      removed_ff   <= removed_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_stall = (state_ff != plq_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: design/plq_checker.sv
// ----------------------------------------------------------------------------
// plq_checker
// Port-level checks of the priority transmit queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module plq_checker #(
   parameter int QUEUE_DEPTH = 64
) (
   input wire              clock,
   input wire              reset,
   input wire              req_valid,
   input wire              req_stall,
   input wire              rsp_valid,
   input wire              rsp_stall,
   input plq_pkg::rsp_type rsp_data
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response word changed")
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall, "request taken while one is in flight")
   `ASSERT_IMPLIES(a_head_occ, clock, reset, rsp_valid, (QUEUE_DEPTH > 127) || (rsp_data.head_valid == (rsp_data.occupancy != 0)), "head_valid disagrees with occupancy")
   `ASSERT_IMPLIES(a_empty_zero, clock, reset, rsp_valid && !rsp_data.head_valid, rsp_data.head_payload == 0 && rsp_data.head_priority == 0, "empty queue reports a head")
   `ASSERT_IMPLIES(a_fail_zero, clock, reset, rsp_valid && !rsp_data.done_res, rsp_data.removed_payload == 0, "failed step reports a removed word")

endmodule

bind priority_linked_tx_queue plq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_plq_checker (.*);

`default_nettype wire

// File: verif/priority_linked_tx_queue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_linked_tx_queue_test
// Drives insert and remove words into the priority transmit queue and checks
// every response against a sorted-list model of the queue. A short table of
// corner cases comes first; random fill, drain and mixed phases follow, with
// random gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------

module priority_linked_tx_queue_test;

   localparam int QUEUE_DEPTH    = 64;
   localparam int PAYLOAD_WIDTH  = 32;
   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 11;
   localparam int RANDOM_WORDS   = 400;
   localparam int DRAIN_CYCLES   = 100;
   localparam int WATCHDOG_LIMIT = 1000;

   localparam logic [plq_pkg::FIELD_W-1:0] PAY_MASK =
      {plq_pkg::FIELD_W{1'b1}} >> (plq_pkg::FIELD_W - PAYLOAD_WIDTH);

   localparam int PH_MIX    = 0;
   localparam int PH_FILL   = 1;
   localparam int PH_DRAIN  = 2;
   localparam int PH_SETTLE = 3;

   typedef struct packed {
      logic [plq_pkg::PRIO_W-1:0]  prio;
      logic [plq_pkg::FIELD_W-1:0] data;
   } tx_entry_type;

   typedef struct packed {
      plq_pkg::req_type word;
      logic             typed;
      plq_pkg::rsp_type want;
   } plan_row_type;

   localparam plq_pkg::rsp_type NO_RSP = '0;
   localparam int PLAN_ROWS = 20;

   // corner-case table; typed rows carry their expected response
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      '{'{plq_pkg::OP_REMOVE, 8'h00, 32'h00000000}, 1'b1,
        '{1'b0, 32'h0, 1'b0, 32'h0, 8'h00, 7'd0}},
      '{'{plq_pkg::OP_INSERT, 8'hff, 32'hffffffff}, 1'b1,
        '{1'b1, 32'h0, 1'b1, 32'hffffffff, 8'hff, 7'd1}},
      '{'{plq_pkg::OP_INSERT, 8'h00, 32'h00000000}, 1'b1,
        '{1'b1, 32'h0, 1'b1, 32'h00000000, 8'h00, 7'd2}},
      '{'{plq_pkg::OP_INSERT, 8'h80, 32'ha5a5a5a5}, 1'b0, NO_RSP},
      '{'{plq_pkg::OP_INSERT, 8'h00, 32'h00000001}, 1'b0, NO_RSP},
      '{'{plq_pkg::OP_INSERT, 8'hff, 32'h5a5a5a5a}, 1'b0, NO_RSP},
      '{'{plq_pkg::OP_INSERT, 8'h7f, 32'h12345678}, 1'b0, NO_RSP},
      '{'{plq_pkg::OP_INSERT, 8'h81, 32'hfedcba98}, 1'b0, NO_RSP},
      '{'{plq_pkg::OP_REMOVE, 8'hff, 32'hffffffff}, 1'b0, NO_RSP},
      '{'{plq_pkg::OP_REMOVE, 8'h00, 32'h00000000}, 1'b0, NO_RSP},
      '{'{plq_pkg::OP_REMOVE, 8'h55, 32'h55555555}, 1'b0, NO_RSP},
      '{'{plq_pkg::OP_REMOVE, 8'haa, 32'haaaaaaaa}, 1'b0, NO_RSP},
      '{'{plq_pkg::OP_REMOVE, 8'h01, 32'h00000001}, 1'b0, NO_RSP},
      '{'{plq_pkg::OP_REMOVE, 8'h00, 32'h00000000}, 1'b0, NO_RSP},
      '{'{plq_pkg::OP_REMOVE, 8'h00, 32'h00000000}, 1'b0, NO_RSP},
      '{'{plq_pkg::OP_REMOVE, 8'hff, 32'hffffffff}, 1'b1,
        '{1'b0, 32'h0, 1'b0, 32'h0, 8'h00, 7'd0}},
      '{'{plq_pkg::OP_INSERT, 8'h01, 32'hdeadbeef}, 1'b1,
        '{1'b1, 32'h0, 1'b1, 32'hdeadbeef, 8'h01, 7'd1}},
      '{'{plq_pkg::OP_INSERT, 8'h00, 32'h00000000}, 1'b0, NO_RSP},
      '{'{plq_pkg::OP_REMOVE, 8'h00, 32'h00000000}, 1'b0, NO_RSP},
      '{'{plq_pkg::OP_REMOVE, 8'h00, 32'h00000000}, 1'b0, NO_RSP}
   };

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   plq_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   plq_pkg::rsp_type rsp_data;

   tx_entry_type     tx_list[$];
   plq_pkg::rsp_type expected_reports[$];
   int      errors = 0;
   int      idle_cycles = 0;
   int      stall_left = 0;
   int      next_gap = 0;
   int      rand_words = 0;
   bit      quiet = 1'b0;
   bit      tie_heavy = 1'b0;

   priority_linked_tx_queue #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic int pause_len();
      return quiet ? 0 : $urandom_range(0, 12);
   endfunction

   task automatic report(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      errors++;
   endtask

   // Advance the sorted queue by one word and build the response it yields.
   task automatic queue_step(input plq_pkg::req_type w, output plq_pkg::rsp_type r);
      tx_entry_type fresh;
      int           pos;
      r = '0;
      if (w.op == plq_pkg::OP_INSERT) begin
         if (tx_list.size() < QUEUE_DEPTH) begin
            fresh.prio = w.priority_req;
            fresh.data = w.payload & PAY_MASK;
            pos = 0;
            // equal priorities stay in arrival order
            while (pos < tx_list.size() && tx_list[pos].prio <= w.priority_req)
               pos++;
            tx_list.insert(pos, fresh);
            r.done_res = 1'b1;
         end
      end else if (tx_list.size() != 0) begin
         r.done_res        = 1'b1;
         r.removed_payload = tx_list[0].data;
         void'(tx_list.pop_front());
      end
      if (tx_list.size() != 0) begin
         r.head_valid    = 1'b1;
         r.head_payload  = tx_list[0].data;
         r.head_priority = tx_list[0].prio;
      end
      r.occupancy = plq_pkg::OCC_W'(tx_list.size());
   endtask

   task automatic send_word(input plq_pkg::req_type w, input logic typed,
                            input plq_pkg::rsp_type want);
      plq_pkg::rsp_type predicted;
      if (next_gap != 0)
         repeat (next_gap) @(posedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      queue_step(w, predicted);
      expected_reports.push_back(typed ? want : predicted);
      // keep valid high when the next word follows at once
      next_gap = pause_len();
      if (next_gap != 0)
         req_valid <= 1'b0;
   endtask

   task automatic send_random(input logic op);
      plq_pkg::req_type w;
      w.op           = op;
      w.priority_req = tie_heavy ? plq_pkg::PRIO_W'($urandom_range(0, 3))
                                 : plq_pkg::PRIO_W'($urandom_range(0, 255));
      w.payload      = $urandom;
      send_word(w, 1'b0, NO_RSP);
      rand_words++;
   endtask

   // Hold off the sender until every expected word has come back.
   task automatic settle();
      if (next_gap == 0)
         req_valid <= 1'b0;
      next_gap = 1;
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   task automatic check_report(input plq_pkg::rsp_type got, input plq_pkg::rsp_type want);
      if (got.done_res !== want.done_res)
         report($sformatf("done_res %0h, expected %0h", got.done_res, want.done_res));
      if (got.removed_payload !== want.removed_payload)
         report($sformatf("removed_payload %h, expected %h",
                          got.removed_payload, want.removed_payload));
      if (got.head_valid !== want.head_valid)
         report($sformatf("head_valid %0h, expected %0h", got.head_valid, want.head_valid));
      if (got.head_payload !== want.head_payload)
         report($sformatf("head_payload %h, expected %h", got.head_payload, want.head_payload));
      if (got.head_priority !== want.head_priority)
         report($sformatf("head_priority %h, expected %h",
                          got.head_priority, want.head_priority));
      if (got.occupancy !== want.occupancy)
         report($sformatf("occupancy %0d, expected %0d", got.occupancy, want.occupancy));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0)
            report("response word with nothing expected");
         else
            check_report(rsp_data, expected_reports.pop_front());
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
         stall_left = pause_len();
         rsp_stall <= (stall_left != 0);
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= (stall_left != 0);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int phase;
      int kind;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_ROWS; i++)
         send_word(PLAN[i].word, PLAN[i].typed, PLAN[i].want);
      settle();

      phase = 0;
      while (rand_words < RANDOM_WORDS) begin
         // start with a fill so the full case is always hit
         kind      = (phase == 0) ? PH_FILL : $urandom_range(PH_MIX, PH_SETTLE);
         tie_heavy = 1'($urandom_range(0, 1));
         case (kind)
            PH_MIX: begin
               repeat (20)
                  send_random(($urandom_range(0, 9) < 6) ? plq_pkg::OP_INSERT
                                                         : plq_pkg::OP_REMOVE);
            end
            PH_FILL: begin
               while (tx_list.size() < QUEUE_DEPTH)
                  send_random(plq_pkg::OP_INSERT);
               repeat ($urandom_range(1, 3))
                  send_random(plq_pkg::OP_INSERT);
            end
            PH_DRAIN: begin
               while (tx_list.size() != 0)
                  send_random(plq_pkg::OP_REMOVE);
               repeat ($urandom_range(1, 2))
                  send_random(plq_pkg::OP_REMOVE);
            end
            default: begin
               settle();
               quiet = !quiet;
            end
         endcase
         phase++;
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_reports.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
